[rtl/tbfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfe_pkg
// Shared types, constants and codes for the three-band FIR equalizer.
// ----------------------------------------------------------------------------
package tbfe_pkg;

  // Filter geometry
  localparam int unsigned TAPS      = 160;
  localparam int unsigned FRAC_BITS = 15;

  // Field widths fixed by the item format
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned GAIN_W   = 15;
  localparam int unsigned TAP_IN_W = 8;

  // Derived widths
  localparam int unsigned ADDR_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned FILL_W      = $clog2(TAPS + 1);
  localparam int unsigned PROD1_W     = SAMPLE_W + COEF_W;
  localparam int unsigned PROD2_W     = PROD1_W + GAIN_W + 1;
  localparam int unsigned ACC_W       = PROD2_W + $clog2(3 * TAPS);
  localparam int unsigned SCALE_SHIFT = GAIN_W + FRAC_BITS;
  localparam int unsigned Q_W         = ACC_W - SCALE_SHIFT;

  // Output range
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // Operation codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Coefficient bank codes
  localparam logic [1:0] BAND_LOW  = 2'd0;
  localparam logic [1:0] BAND_MID  = 2'd1;
  localparam logic [1:0] BAND_HIGH = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_HIGH = 2'd2;

  // Gain reset values (unsigned Q0.15: about 0.1, 0.5, 0.9)
  localparam logic [GAIN_W-1:0] GAIN_LOW_RST  = 15'd3277;
  localparam logic [GAIN_W-1:0] GAIN_MID_RST  = 15'd16384;
  localparam logic [GAIN_W-1:0] GAIN_HIGH_RST = 15'd29491;

  typedef struct packed {
    logic                       operation;
    logic [1:0]                 band_select;
    logic [TAP_IN_W-1:0]        tap_index;
    logic signed [COEF_W-1:0]   coefficient;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic              push_sample;
    logic              load_coef;
    logic              clear_acc;
    logic              issue;
    logic [1:0]        band;
    logic [ADDR_W-1:0] tap;
    logic              load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

endpackage

[rtl/tbfe_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfe_datapath
// Gain registers, coefficient banks, circular delay line, shared MAC
// pipeline, rounding toward zero with saturation and the result register.
// ----------------------------------------------------------------------------
module tbfe_datapath
  import tbfe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAIN_W-1:0]    cfg_wdata_i,
  input  in_item_t             in_data_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  output out_item_t            out_data_o
);

  localparam logic [ADDR_W:0] TAPS_X = (ADDR_W + 1)'(TAPS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TAPS - 1);
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(SAMPLE_MAX);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(SAMPLE_MIN);

  logic [GAIN_W-1:0] gain_low_q, gain_mid_q, gain_high_q;

  logic signed [COEF_W-1:0]   coef_lo_mem [TAPS];
  logic signed [COEF_W-1:0]   coef_md_mem [TAPS];
  logic signed [COEF_W-1:0]   coef_hi_mem [TAPS];
  logic signed [SAMPLE_W-1:0] dly_mem     [TAPS];

  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [FILL_W-1:0] fill_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W:0]   rd_wrap;
  logic              tap_ok;

  logic signed [COEF_W-1:0]   coef_lo_q, coef_md_q, coef_hi_q;
  logic signed [SAMPLE_W-1:0] dly_q;
  logic                       dvalid_q;
  logic                       v1_q, v2_q, v3_q;
  logic [1:0]                 b1_q, b2_q;
  logic signed [COEF_W-1:0]   coef_sel;
  logic signed [SAMPLE_W-1:0] dly_masked;
  logic [GAIN_W-1:0]          gain_sel;
  logic signed [PROD1_W-1:0]  prod1_q;
  logic signed [PROD2_W-1:0]  prod2_q;
  logic signed [ACC_W-1:0]    acc_q;

  logic signed [Q_W-1:0] q_floor, q_trunc;
  logic                  frac_nz, sat_hi, sat_lo;
  out_item_t             out_q;

  // Gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_low_q  <= GAIN_LOW_RST;
      gain_mid_q  <= GAIN_MID_RST;
      gain_high_q <= GAIN_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_LOW:  gain_low_q  <= cfg_wdata_i;
        REG_GAIN_MID:  gain_mid_q  <= cfg_wdata_i;
        REG_GAIN_HIGH: gain_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Coefficient loads: drop out-of-range taps and unknown banks
  assign tap_ok = int'(in_data_i.tap_index) < TAPS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_coef && tap_ok) begin
      case (in_data_i.band_select)
        BAND_LOW:  coef_lo_mem[ADDR_W'(in_data_i.tap_index)] <= in_data_i.coefficient;
        BAND_MID:  coef_md_mem[ADDR_W'(in_data_i.tap_index)] <= in_data_i.coefficient;
        BAND_HIGH: coef_hi_mem[ADDR_W'(in_data_i.tap_index)] <= in_data_i.coefficient;
        default: ;
      endcase
    end
    if (cmd_i.issue) begin
      coef_lo_q <= coef_lo_mem[cmd_i.tap];
      coef_md_q <= coef_md_mem[cmd_i.tap];
      coef_hi_q <= coef_hi_mem[cmd_i.tap];
    end
  end

  // Delay line pointer and fill count; entries past the fill read as zero
  assign wp_d = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (cmd_i.push_sample) begin
      wp_q <= wp_d;
      if (int'(fill_q) < TAPS) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Tap n sits n entries behind the newest sample
  assign rd_wrap = {1'b0, wp_q} + TAPS_X - {1'b0, cmd_i.tap};
  assign rd_addr = (wp_q >= cmd_i.tap) ? wp_q - cmd_i.tap : rd_wrap[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_sample) begin
      dly_mem[wp_d] <= in_data_i.sample_in;
    end
    if (cmd_i.issue) begin
      dly_q    <= dly_mem[rd_addr];
      dvalid_q <= FILL_W'(cmd_i.tap) < fill_q;
    end
  end

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      b1_q <= BAND_LOW;
      b2_q <= BAND_LOW;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      b1_q <= cmd_i.band;
      b2_q <= b1_q;
    end
  end

  // Select bank coefficient and gain for the tagged band
  always_comb begin
    case (b1_q)
      BAND_LOW:  coef_sel = coef_lo_q;
      BAND_MID:  coef_sel = coef_md_q;
      default:   coef_sel = coef_hi_q;
    endcase
    case (b2_q)
      BAND_LOW:  gain_sel = gain_low_q;
      BAND_MID:  gain_sel = gain_mid_q;
      default:   gain_sel = gain_high_q;
    endcase
  end

  assign dly_masked = dvalid_q ? dly_q : '0;

  // Coefficient times sample, then times gain
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod1_q <= coef_sel * dly_masked;
    end
    if (v2_q) begin
      prod2_q <= prod1_q * $signed({1'b0, gain_sel});
    end
  end

  // Accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_acc) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + ACC_W'(prod2_q);
    end
  end

  assign status_o.pipe_busy = v1_q | v2_q | v3_q;

  // Scale back, truncate toward zero, saturate
  assign q_floor = acc_q[ACC_W-1:SCALE_SHIFT];
  assign frac_nz = |acc_q[SCALE_SHIFT-1:0];
  assign q_trunc = q_floor + Q_W'(acc_q[ACC_W-1] & frac_nz);
  assign sat_hi  = q_trunc > Q_MAX;
  assign sat_lo  = q_trunc < Q_MIN;

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.saturated <= sat_hi | sat_lo;
      if (sat_hi) begin
        out_q.sample_out <= SAMPLE_W'(SAMPLE_MAX);
      end else if (sat_lo) begin
        out_q.sample_out <= SAMPLE_W'(SAMPLE_MIN);
      end else begin
        out_q.sample_out <= q_trunc[SAMPLE_W-1:0];
      end
    end
  end

  assign out_data_o = out_q;

endmodule

[rtl/tbfe_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfe_ctrl
// Sequencer: accepts items, walks the three banks tap by tap through the
// shared MAC, waits for the pipeline to drain and hands off the result.
// ----------------------------------------------------------------------------
module tbfe_ctrl
  import tbfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_operation_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [ADDR_W-1:0] LAST_TAP = ADDR_W'(TAPS - 1);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] tap_q, tap_d;
  logic [1:0]        band_q, band_d;
  logic              out_valid_q, out_valid_d;
  logic              last_step;

  assign last_step = (band_q == BAND_HIGH) && (tap_q == LAST_TAP);

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= '0;
      band_q      <= BAND_LOW;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      band_q      <= band_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d           = state_q;
    tap_d             = tap_q;
    band_d            = band_q;
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.tap         = tap_q;
    cmd_o.band        = band_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_operation_i == OP_LOAD) begin
            cmd_o.load_coef = 1'b1;
          end else begin
            cmd_o.push_sample = 1'b1;
            cmd_o.clear_acc   = 1'b1;
            tap_d             = '0;
            band_d            = BAND_LOW;
            state_d           = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd_o.issue = 1'b1;
        if (last_step) begin
          state_d = ST_FLUSH;
        end else if (tap_q == LAST_TAP) begin
          tap_d  = '0;
          band_d = band_q + 2'd1;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!status_i.pipe_busy && (!out_valid_q || out_ready_i)) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold a result until it is transferred
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // The pipeline is empty whenever new items can be taken
  a_idle_pipe_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !status_i.pipe_busy)
    else $error("MAC pipeline busy while idle");

  // The last MAC step hands over to the drain phase
  a_last_to_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC && last_step) |=> state_q == ST_FLUSH)
    else $error("sequencer missed the end of the tap walk");

  // Issued taps and banks stay in range
  a_issue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> (int'(tap_q) < TAPS) && (band_q != 2'd3))
    else $error("tap or band counter out of range");

  // A pending result is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

endmodule

[rtl/three_band_fir_equalizer.sv]
`timescale 1ns / 1ps
// Operation: the single shared multiply-accumulate unit walks every tap of all
// three banks for each sample, and no new item is taken until that sample's
// result has been loaded into the result register, which back-pressure can delay.
// Reset: gains return to their defaults and the delay line reads as zeros;
// coefficient banks are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// three_band_fir_equalizer
// Three-band FIR equalizer on signed 16-bit samples with per-band gains.
// ----------------------------------------------------------------------------
module three_band_fir_equalizer
  import tbfe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAIN_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  tbfe_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_operation_i (in_data_i.operation),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  // Storage and arithmetic
  tbfe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-band FIR equalizer. Zeroes every
// coefficient bank, walks a short table of directed items (extremes, ignored
// loads, saturation, gain settings), then runs random phases of coefficient
// loads and samples under random or extreme gains, mostly with back-pressure. Each
// filtered sample is checked against a bit-exact equalizer model kept here or its directed row's value.
// ----------------------------------------------------------------------------
module tb;
  import tbfe_pkg::*;

  localparam int DRAIN_CYCLES = 3 * TAPS + 8;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 50;
  localparam int TIMEOUT_NS   = 80_000_000;
  localparam int COEF_SHIFT [PHASES] = '{2, 5, 0, 7, 4};

  localparam logic [1:0]           BAND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
  localparam logic [1:0]           BANDS [3] = '{BAND_LOW, BAND_MID, BAND_HIGH};
  localparam logic [CFG_IDX_W-1:0] GAIN_REGS [3] =
    '{REG_GAIN_LOW, REG_GAIN_MID, REG_GAIN_HIGH};
  localparam logic [GAIN_W-1:0]    GAIN_MAX = '1;

  typedef enum logic {ROW_ITEM, ROW_GAINS} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    in_item_t                 item;
    bit                       typed;
    out_item_t                want;
    logic [2:0][GAIN_W-1:0]   gains;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [GAIN_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;

  // Model state of the equalizer
  logic signed [SAMPLE_W-1:0] delay_q [TAPS];
  logic signed [COEF_W-1:0]   coef_q [3][TAPS];
  logic [2:0][GAIN_W-1:0]     gain_q;

  out_item_t pending_outputs [$];
  row_t      directed [$];
  int        mismatch_count = 0;
  bit        idle_en = 1'b1;

  three_band_fir_equalizer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #6 clk = ~clk;

  // Count a failure, report only the first few
  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Gap before a transfer: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (!idle_en || roll < 60) return 0;
    if (roll < 92) return $urandom_range(4, 1);
    return $urandom_range(300, 20);
  endfunction

  function automatic int pick_stall();
    int roll;
    roll = $urandom_range(99);
    if (!idle_en || roll < 65) return 0;
    if (roll < 95) return $urandom_range(5, 1);
    return $urandom_range(200, 30);
  endfunction

  // Store one coefficient word; bad bank or tap out of range is dropped
  function automatic void store_coefficient(input in_item_t it);
    if (it.tap_index < TAPS) begin
      case (it.band_select)
        BAND_LOW, BAND_MID, BAND_HIGH: coef_q[it.band_select][it.tap_index] = it.coefficient;
        default: ;
      endcase
    end
  endfunction

  // Shift the sample in, form the exact three-band sum, truncate and clip
  function automatic out_item_t equalize_sample(input logic signed [SAMPLE_W-1:0] s);
    longint    acc;
    longint    mag;
    out_item_t r;
    for (int n = TAPS - 1; n > 0; n--) delay_q[n] = delay_q[n - 1];
    delay_q[0] = s;
    acc = 0;
    for (int b = 0; b < 3; b++) begin
      for (int n = 0; n < TAPS; n++) begin
        acc += longint'(gain_q[b]) * longint'(coef_q[b][n]) * longint'(delay_q[n]);
      end
    end
    r.saturated = 1'b0;
    if (acc < 0) begin
      mag = (-acc) >> SCALE_SHIFT;
      if (mag > 32768) begin
        r.sample_out = SAMPLE_W'(SAMPLE_MIN);
        r.saturated  = 1'b1;
      end else begin
        r.sample_out = SAMPLE_W'(-mag);
      end
    end else begin
      mag = acc >> SCALE_SHIFT;
      if (mag > 32767) begin
        r.sample_out = SAMPLE_W'(SAMPLE_MAX);
        r.saturated  = 1'b1;
      end else begin
        r.sample_out = SAMPLE_W'(mag);
      end
    end
    return r;
  endfunction

  function automatic in_item_t make_sample(input logic signed [SAMPLE_W-1:0] s);
    in_item_t it;
    it.operation   = OP_FILTER;
    it.band_select = 2'($urandom);
    it.tap_index   = TAP_IN_W'($urandom);
    it.coefficient = COEF_W'($urandom);
    it.sample_in   = s;
    return it;
  endfunction

  function automatic in_item_t make_load(input logic [1:0] band, input int tap,
                                         input int c);
    in_item_t it;
    it.operation   = OP_LOAD;
    it.band_select = band;
    it.tap_index   = TAP_IN_W'(tap);
    it.coefficient = COEF_W'(c);
    it.sample_in   = SAMPLE_W'($urandom);
    return it;
  endfunction

  function automatic row_t row_load(input logic [1:0] band, input int tap,
                                    input int c);
    row_t r;
    r.kind  = ROW_ITEM;
    r.item  = make_load(band, tap, c);
    r.typed = 1'b0;
    r.want  = '0;
    r.gains = '0;
    return r;
  endfunction

  function automatic row_t row_sample(input int s);
    row_t r;
    r.kind  = ROW_ITEM;
    r.item  = make_sample(SAMPLE_W'(s));
    r.typed = 1'b0;
    r.want  = '0;
    r.gains = '0;
    return r;
  endfunction

  function automatic row_t row_check(input int s, input int y, input logic sat);
    row_t r;
    r = row_sample(s);
    r.typed = 1'b1;
    r.want.sample_out = SAMPLE_W'(y);
    r.want.saturated  = sat;
    return r;
  endfunction

  function automatic row_t row_gains(input logic [GAIN_W-1:0] g_low,
                                     input logic [GAIN_W-1:0] g_mid,
                                     input logic [GAIN_W-1:0] g_high);
    row_t r;
    r.kind  = ROW_GAINS;
    r.item  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    r.gains = {g_high, g_mid, g_low};
    return r;
  endfunction

  // Present one item, hold it until the transfer, then update the model
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t exp_out;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.operation == OP_FILTER) begin
      exp_out = equalize_sample(it.sample_in);
      if (typed) exp_out = want;
      pending_outputs.push_back(exp_out);
    end else begin
      store_coefficient(it);
    end
  endtask

  // Hold off the sender until every result has been collected
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Drain the block, then write all gains plus the unused index
  task automatic program_gains(input logic [2:0][GAIN_W-1:0] g);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int j = 0; j < 3; j++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= GAIN_REGS[j];
      cfg_wdata <= g[j];
      gain_q[j]  = g[j];
      @(posedge clk);
    end
    cfg_idx   <= REG_UNUSED;
    cfg_wdata <= GAIN_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result sink: check each transfer, stall at random
  initial begin
    int        stall_left;
    out_item_t exp_out;
    out_ready <= 1'b0;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_outputs.size() == 0) begin
          note_failure($sformatf("result %0d/%0d with nothing expected",
                                 out_data.sample_out, out_data.saturated));
        end else begin
          exp_out = pending_outputs.pop_front();
          if (out_data.sample_out !== exp_out.sample_out) begin
            note_failure($sformatf("sample_out expected %0d got %0d",
                                   exp_out.sample_out, out_data.sample_out));
          end
          if (out_data.saturated !== exp_out.saturated) begin
            note_failure($sformatf("saturated expected %0b got %0b",
                                   exp_out.saturated, out_data.saturated));
          end
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_stall();
      end
    end
  end

  // Stimulus
  initial begin
    int                      counted;
    int                      roll;
    logic [2:0][GAIN_W-1:0]  g;
    logic signed [COEF_W-1:0] c;
    logic signed [SAMPLE_W-1:0] s;
    in_item_t                it;

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_GAIN_LOW;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    gain_q    = {GAIN_HIGH_RST, GAIN_MID_RST, GAIN_LOW_RST};
    for (int n = 0; n < TAPS; n++) begin
      delay_q[n] = '0;
      for (int b = 0; b < 3; b++) coef_q[b][n] = '0;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Zero every coefficient so no unwritten entry is ever read
    for (int b = 0; b < 3; b++) begin
      for (int n = 0; n < TAPS; n++) send_item(make_load(BANDS[b], n, 0), 1'b0, '0);
    end

    // Directed table, default gains first
    directed.push_back(row_check(SAMPLE_MAX, 0, 1'b0));
    directed.push_back(row_check(SAMPLE_MIN, 0, 1'b0));
    directed.push_back(row_load(BAND_LOW, 0, SAMPLE_MIN));
    directed.push_back(row_load(BAND_MID, 0, SAMPLE_MIN));
    directed.push_back(row_load(BAND_HIGH, 0, SAMPLE_MIN));
    directed.push_back(row_load(BAND_UNUSED, 0, 12345));
    directed.push_back(row_load(BAND_LOW, TAPS, SAMPLE_MAX));
    directed.push_back(row_load(BAND_MID, 255, -1));
    directed.push_back(row_check(SAMPLE_MIN, SAMPLE_MAX, 1'b1));
    directed.push_back(row_check(SAMPLE_MAX, SAMPLE_MIN, 1'b1));
    directed.push_back(row_check(0, 0, 1'b0));
    directed.push_back(row_load(BAND_LOW, TAPS - 1, SAMPLE_MAX));
    directed.push_back(row_load(BAND_MID, TAPS - 1, SAMPLE_MAX));
    directed.push_back(row_load(BAND_HIGH, TAPS - 1, SAMPLE_MIN));
    directed.push_back(row_load(BAND_LOW, 1, SAMPLE_MAX));
    directed.push_back(row_sample(1));
    directed.push_back(row_sample(-1));
    directed.push_back(row_gains('0, '0, '0));
    directed.push_back(row_check(12345, 0, 1'b0));
    directed.push_back(row_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX));
    directed.push_back(row_check(SAMPLE_MIN, SAMPLE_MAX, 1'b1));
    directed.push_back(row_sample(SAMPLE_MAX));
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_GAINS) program_gains(directed[i].gains);
      else send_item(directed[i].item, directed[i].typed, directed[i].want);
    end

    // Random phases: new gains, then mixed loads and samples
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       g = {GAIN_MAX, GAIN_MAX, GAIN_MAX};
        2:       g = {GAIN_W'(0), GAIN_MAX, GAIN_W'(0)};
        4:       g = {GAIN_W'(0), GAIN_W'(0), GAIN_MAX};
        default: g = {GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom)};
      endcase
      program_gains(g);
      idle_en = (p != 3);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 20) begin
          c = COEF_W'($urandom);
          c = c >>> COEF_SHIFT[p];
          send_item(make_load(BANDS[$urandom_range(2)], $urandom_range(TAPS - 1), int'(c)),
                    1'b0, '0);
          counted++;
        end else if (roll < 25) begin
          // Dropped loads: bad bank or tap past the end
          if ($urandom_range(1) == 0) begin
            it = make_load(BAND_UNUSED, $urandom_range(255), $urandom);
          end else begin
            it = make_load(BANDS[$urandom_range(2)], $urandom_range(255, TAPS), $urandom);
          end
          send_item(it, 1'b0, '0);
        end else begin
          roll = $urandom_range(99);
          if (roll < 3) s = SAMPLE_W'(SAMPLE_MAX);
          else if (roll < 6) s = SAMPLE_W'(SAMPLE_MIN);
          else if (roll < 20) s = $signed(SAMPLE_W'($urandom)) >>> 8;
          else s = SAMPLE_W'($urandom);
          if ($urandom_range(49) == 0) hold_until_drained();
          send_item(make_sample(s), 1'b0, '0);
          counted++;
        end
      end
    end

    // Wait for the last results, then let the block settle
    in_valid <= 1'b0;
    idle_en = 1'b1;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/tbfe_pkg.sv
rtl/tbfe_datapath.sv
rtl/tbfe_ctrl.sv
rtl/three_band_fir_equalizer.sv
test/tb.sv
